@@ design/actk_pkg.sv @@
// Shared types, constants and helper functions of the alarm clock time keeper.
`default_nettype none

package actk_pkg;

  localparam int unsigned SEC_LIMIT    = 60;
  localparam int unsigned MIN_LIMIT    = 60;
  localparam int unsigned HOUR_LIMIT   = 24;
  localparam int unsigned SEC_W        = 6;
  localparam int unsigned MIN_W        = 6;
  localparam int unsigned HOUR_W       = 5;
  localparam int unsigned WINDOW_W     = 6;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd30;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_UP   = 2'd2,
    KIND_DOWN = 2'd3
  } actk_kind_e;

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_SEC  = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_HOUR = 2'd3
  } actk_mode_e;

  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;

  // Edit command for one counter cell.
  typedef struct packed {
    logic step_en;
    logic step_up;
  } actk_cell_ctrl_t;

  // Edit commands for all five cells of the row.
  typedef struct packed {
    actk_cell_ctrl_t sec;
    actk_cell_ctrl_t min;
    actk_cell_ctrl_t hour;
    actk_cell_ctrl_t amin;
    actk_cell_ctrl_t ahour;
    logic            tick;
  } actk_cells_ctrl_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } actk_digits_t;

  // Splits a value below 64 into decimal digits; v * 13 / 128 equals v / 10 there.
  function automatic actk_digits_t split_digits(input logic [5:0] v);
    logic [9:0]   prod;
    logic [5:0]   rem;
    actk_digits_t d;
    prod   = {4'd0, v} * 10'd13;
    d.tens = prod[9:7];
    rem    = v - 6'({3'd0, d.tens} * 6'd10);
    d.ones = rem[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/actk_unit_cell.sv @@
// One wrap-around counter cell of the time row with carry to its neighbor.
`default_nettype none

module actk_unit_cell
  import actk_pkg::*;
#(
  parameter int unsigned W     = 6,
  parameter int unsigned LIMIT = 60
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire actk_cell_ctrl_t ctrl_i,
  input  wire logic            carry_i,
  output logic [W-1:0]         value_o,
  output logic [W-1:0]         value_next_o,
  output logic                 carry_o
);

  localparam logic [W:0]   LimitExt = (W+1)'(LIMIT);
  localparam logic [W-1:0] LimitM1  = W'(LIMIT - 1);

  logic [W-1:0] value_q, value_d;
  logic [W:0]   inc;
  logic         wrap_up;
  logic [W-1:0] up_val, down_val;

  assign inc      = {1'b0, value_q} + (W+1)'(1);
  assign wrap_up  = (inc >= LimitExt);
  assign up_val   = wrap_up ? '0 : inc[W-1:0];
  assign down_val = ((value_q == '0) || ({1'b0, value_q} >= LimitExt)) ?
                    LimitM1 : value_q - W'(1);

  always_comb begin
    value_d = value_q;
    if (carry_i) begin
      value_d = up_val;
    end else if (ctrl_i.step_en) begin
      value_d = ctrl_i.step_up ? up_val : down_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o      = value_q;
  assign value_next_o = value_d;
  assign carry_o      = carry_i & wrap_up;

endmodule

`default_nettype wire

@@ design/actk_ctrl.sv @@
// Set-mode state machine, event decode, buzzer and refusal flags.
`default_nettype none

module actk_ctrl
  import actk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic        edit_alarm_i,
  input  wire logic        alarm_enable_i,
  input  wire logic        alarm_match_i,
  output actk_cells_ctrl_t cells_o,
  output logic             in_set_mode_o,
  output logic [1:0]       unit_selected_o,
  output logic             alarm_sound_o,
  output logic             request_refused_o
);

  actk_mode_e mode_q, mode_d;
  actk_kind_e kind;
  logic       buzzer_q, buzzer_d;
  logic       refused_q, refused_d;
  logic       step_ev, step_up;

  assign kind    = actk_kind_e'(kind_i);
  assign step_ev = accept_i && (kind == KIND_UP || kind == KIND_DOWN) && (mode_q != MODE_RUN);
  assign step_up = (kind == KIND_UP);

  // Next state: the set button walks run -> seconds -> minutes -> hours -> run.
  always_comb begin
    mode_d = mode_q;
    if (accept_i && kind == KIND_SET) begin
      unique case (mode_q)
        MODE_RUN:  mode_d = MODE_SEC;
        MODE_SEC:  mode_d = MODE_MIN;
        MODE_MIN:  mode_d = MODE_HOUR;
        MODE_HOUR: mode_d = MODE_RUN;
        default:   mode_d = MODE_RUN;
      endcase
    end
  end

  // Outputs of the state machine and the cell edit commands.
  always_comb begin
    cells_o         = '0;
    in_set_mode_o   = 1'b1;
    unit_selected_o = UNIT_SEC;
    unique case (mode_q)
      MODE_RUN: begin
        in_set_mode_o = 1'b0;
      end
      MODE_SEC: begin
        unit_selected_o = UNIT_SEC;
        cells_o.sec     = '{step_en: step_ev && !edit_alarm_i, step_up: step_up};
      end
      MODE_MIN: begin
        unit_selected_o = UNIT_MIN;
        cells_o.min     = '{step_en: step_ev && !edit_alarm_i, step_up: step_up};
        cells_o.amin    = '{step_en: step_ev && edit_alarm_i, step_up: step_up};
      end
      MODE_HOUR: begin
        unit_selected_o = UNIT_HOUR;
        cells_o.hour    = '{step_en: step_ev && !edit_alarm_i, step_up: step_up};
        cells_o.ahour   = '{step_en: step_ev && edit_alarm_i, step_up: step_up};
      end
      default: begin
        in_set_mode_o = 1'b0;
      end
    endcase
    cells_o.tick = accept_i && (kind == KIND_TICK) && (mode_q == MODE_RUN);
  end

  always_comb begin
    buzzer_d  = buzzer_q;
    refused_d = refused_q;
    if (accept_i) begin
      refused_d = step_ev && edit_alarm_i && (mode_q == MODE_SEC);
      if (kind == KIND_SET) begin
        buzzer_d = 1'b0;
      end else if (kind == KIND_TICK && mode_q == MODE_RUN) begin
        buzzer_d = alarm_enable_i && alarm_match_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RUN;
      buzzer_q  <= 1'b0;
      refused_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      buzzer_q  <= buzzer_d;
      refused_q <= refused_d;
    end
  end

  assign alarm_sound_o     = buzzer_q;
  assign request_refused_o = refused_q;

endmodule

`default_nettype wire

@@ design/alarm_clock_time_keeper.sv @@
// Top level of the 24-hour alarm clock time keeper.
//
// Usage: each input transaction on the in_valid_i / in_ready_o channel carries
// one event (second tick, set, up or down) plus the edit and enable switches.
// Every event produces exactly one output transaction on out_valid_o /
// out_ready_i that reports the time as decimal digits, the alarm setting and
// the mode status after the event has been applied.
// The state lives in a row of counter cells (seconds, minutes, hours, then
// alarm minute and alarm hour); a tick ripples as a carry from cell to cell.
// The result of an event is registered at the edge that accepts it and is
// valid right after that edge. Throughput is one event per cycle as long as
// the receiver takes each result. While the receiver stalls, the pending result
// is held in the state registers themselves and no new event is taken.
// Reset clears the time, the alarm and all flags, leaves set mode and sets the
// alarm window to 30 seconds. The window register is written through
// cfg_we_i / cfg_wdata_i and should only be changed while the block is idle.
`default_nettype none

module alarm_clock_time_keeper
  import actk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [WINDOW_W-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          kind_i,
  input  wire logic                edit_alarm_i,
  input  wire logic                alarm_enable_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               hour_tens_o,
  output logic [3:0]               hour_ones_o,
  output logic [2:0]               minute_tens_o,
  output logic [3:0]               minute_ones_o,
  output logic [2:0]               second_tens_o,
  output logic [3:0]               second_ones_o,
  output logic                     alarm_sound_o,
  output logic                     in_set_mode_o,
  output logic [1:0]               unit_selected_o,
  output logic [HOUR_W-1:0]        alarm_hour_out_o,
  output logic [MIN_W-1:0]         alarm_minute_out_o,
  output logic                     request_refused_o
);

  logic                in_accept;
  logic                out_valid_q, out_valid_d;
  logic [WINDOW_W-1:0] window_q;
  actk_cells_ctrl_t    cells;

  logic [SEC_W-1:0]    sec_q, sec_next;
  logic [MIN_W-1:0]    min_q, min_next, amin_q, amin_next;
  logic [HOUR_W-1:0]   hour_q, hour_next, ahour_q, ahour_next;
  logic                sec_carry, min_carry, hour_carry, amin_carry, ahour_carry;
  logic                alarm_match;
  actk_digits_t        sec_dig, min_dig, hour_dig;

  // The state registers double as the output register, so a new event is
  // taken only when no result is pending or the pending one leaves now.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      window_q    <= WINDOW_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  actk_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .accept_i          (in_accept),
    .kind_i,
    .edit_alarm_i,
    .alarm_enable_i,
    .alarm_match_i     (alarm_match),
    .cells_o           (cells),
    .in_set_mode_o,
    .unit_selected_o,
    .alarm_sound_o,
    .request_refused_o
  );

  // Time row: the tick enters the seconds cell and carries on to the left.
  actk_unit_cell #(.W(SEC_W), .LIMIT(SEC_LIMIT)) u_sec (
    .clk_i, .rst_ni, .ctrl_i(cells.sec), .carry_i(cells.tick),
    .value_o(sec_q), .value_next_o(sec_next), .carry_o(sec_carry)
  );

  actk_unit_cell #(.W(MIN_W), .LIMIT(MIN_LIMIT)) u_min (
    .clk_i, .rst_ni, .ctrl_i(cells.min), .carry_i(sec_carry),
    .value_o(min_q), .value_next_o(min_next), .carry_o(min_carry)
  );

  actk_unit_cell #(.W(HOUR_W), .LIMIT(HOUR_LIMIT)) u_hour (
    .clk_i, .rst_ni, .ctrl_i(cells.hour), .carry_i(min_carry),
    .value_o(hour_q), .value_next_o(hour_next), .carry_o(hour_carry)
  );

  // Alarm row: same cells, edited only by the buttons, never ticked.
  actk_unit_cell #(.W(MIN_W), .LIMIT(MIN_LIMIT)) u_amin (
    .clk_i, .rst_ni, .ctrl_i(cells.amin), .carry_i(1'b0),
    .value_o(amin_q), .value_next_o(amin_next), .carry_o(amin_carry)
  );

  actk_unit_cell #(.W(HOUR_W), .LIMIT(HOUR_LIMIT)) u_ahour (
    .clk_i, .rst_ni, .ctrl_i(cells.ahour), .carry_i(1'b0),
    .value_o(ahour_q), .value_next_o(ahour_next), .carry_o(ahour_carry)
  );

  // The alarm compares the time after the tick; the alarm setting does not
  // change on a tick, so its next value equals its current one then.
  assign alarm_match = (hour_next == ahour_next) && (min_next == amin_next) &&
                       (sec_next < window_q);

  assign sec_dig  = split_digits(sec_q);
  assign min_dig  = split_digits(min_q);
  assign hour_dig = split_digits({1'b0, hour_q});

  assign out_valid_o        = out_valid_q;
  assign hour_tens_o        = hour_dig.tens[1:0];
  assign hour_ones_o        = hour_dig.ones;
  assign minute_tens_o      = min_dig.tens;
  assign minute_ones_o      = min_dig.ones;
  assign second_tens_o      = sec_dig.tens;
  assign second_ones_o      = sec_dig.ones;
  assign alarm_hour_out_o   = ahour_q;
  assign alarm_minute_out_o = amin_q;

  // Counting mode always reports the seconds unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_set_mode_o |-> unit_selected_o == UNIT_SEC)
    else $error("unit selected outside set mode");

  // A refusal only arises while editing seconds in set mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    request_refused_o |-> in_set_mode_o && unit_selected_o == UNIT_SEC)
    else $error("refusal outside seconds set mode");

  // A tick taken in set mode leaves the time untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KIND_TICK && in_set_mode_o)
      |=> $stable(sec_q) && $stable(min_q) && $stable(hour_q))
    else $error("tick counted in set mode");

  // The seconds and hours counters never leave their range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q < SEC_W'(SEC_LIMIT)) && (hour_q < HOUR_W'(HOUR_LIMIT)))
    else $error("counter out of range");

  // The alarm cells are never ticked, and the hours cell carries only when
  // the time rolls over to midnight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(amin_carry || ahour_carry) &&
    (!hour_carry || (hour_next == '0 && min_next == '0 && sec_next == '0)))
    else $error("unexpected carry in the cell row");

endmodule

`default_nettype wire
